// File: src/wps_pkg.sv
`timescale 1ns / 1ps

package wps_pkg;

  // Parse phases
  localparam logic [3:0] PH_RIFF_ID   = 4'd0;
  localparam logic [3:0] PH_RIFF_SIZE = 4'd1;
  localparam logic [3:0] PH_WAVE_ID   = 4'd2;
  localparam logic [3:0] PH_SUB_ID    = 4'd3;
  localparam logic [3:0] PH_SUB_SIZE  = 4'd4;
  localparam logic [3:0] PH_FMT_BODY  = 4'd5;
  localparam logic [3:0] PH_SKIP      = 4'd6;
  localparam logic [3:0] PH_DATA      = 4'd7;
  localparam logic [3:0] PH_HALT      = 4'd8;

  // Chunk identifiers, first byte in the top octet
  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [31:0] FMT_BODY_BYTES = 32'd16;
  localparam logic [15:0] BITS_8         = 16'd8;
  localparam logic [15:0] BITS_16        = 16'd16;

  // Result kinds
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_FORMAT = 2'd1;
  localparam logic [1:0] KIND_EOF    = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  // Error codes
  localparam logic [2:0] ERR_BAD_RIFF      = 3'd0;
  localparam logic [2:0] ERR_BAD_WAVE      = 3'd1;
  localparam logic [2:0] ERR_TRUNC_HEADER  = 3'd2;
  localparam logic [2:0] ERR_TRUNC_CHUNK   = 3'd3;
  localparam logic [2:0] ERR_UNSUP_BITS    = 3'd4;
  localparam logic [2:0] ERR_NONE          = 3'd0;

  typedef struct packed {
    logic [1:0]         kind;
    logic [2:0]         error_code;
    logic signed [15:0] sample_value;
    logic [15:0]        channel_count;
    logic [31:0]        rate_hz;
    logic [15:0]        sample_bits;
    logic [15:0]        format_tag;
    logic [31:0]        bytes_per_second;
    logic [15:0]        frame_bytes;
    logic               is_final;
  } wps_result_t;

endpackage

// File: src/wav_pcm_stream_parser.sv
`timescale 1ns / 1ps

// A result is registered in the output register, or in the skid register while that one holds an untaken result.
// One byte per clock while in_ready is high; the parse state updates in a single pass per byte.
// A two-entry output (result register plus skid register) keeps input flowing while a
// result waits; in_ready drops only when both entries hold a request.
// Reset (rst, synchronous): parse returns to the RIFF identifier, held fmt fields clear,
// pending results are dropped.
module wav_pcm_stream_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic               stream_end,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         kind,
  output logic [2:0]         error_code,
  output logic signed [15:0] sample_value,
  output logic [15:0]        channel_count,
  output logic [31:0]        rate_hz,
  output logic [15:0]        sample_bits,
  output logic [15:0]        format_tag,
  output logic [31:0]        bytes_per_second,
  output logic [15:0]        frame_bytes,
  output logic               is_final
);
  import wps_pkg::*;

  // Parse state
  logic [3:0]  phase, phase_next;
  logic [3:0]  pos, pos_next;          // byte index within the current field or body
  logic [31:0] tag, tag_next;
  logic [31:0] len, len_next;
  logic [15:0] held_format_tag, held_format_tag_next;
  logic [15:0] held_channels, held_channels_next;
  logic [31:0] held_rate, held_rate_next;
  logic [31:0] held_byte_rate, held_byte_rate_next;
  logic [15:0] held_block_align, held_block_align_next;
  logic [15:0] held_bits, held_bits_next;
  logic [7:0]  low_byte, low_byte_next;

  // Output storage
  wps_result_t res, res_next, skid;
  logic        skid_full;
  logic        emit;
  logic        accept;

  logic [31:0] tag_sh;
  logic [3:0]  pos_inc;
  logic [31:0] len_put;
  logic [1:0]  r_kind;
  logic [2:0]  r_err;
  logic [15:0] r_smp;

  assign in_ready = !skid_full;
  assign accept   = in_valid && in_ready;

  assign tag_sh  = {tag[23:0], data_byte};
  assign pos_inc = pos + 4'd1;

  always_comb begin
    len_put = len;
    len_put[{pos[1:0], 3'b000} +: 8] = data_byte;
  end

  // One byte of parsing
  always_comb begin
    phase_next            = phase;
    pos_next              = pos;
    tag_next              = tag;
    len_next              = len;
    held_format_tag_next  = held_format_tag;
    held_channels_next    = held_channels;
    held_rate_next        = held_rate;
    held_byte_rate_next   = held_byte_rate;
    held_block_align_next = held_block_align;
    held_bits_next        = held_bits;
    low_byte_next         = low_byte;
    emit                  = 1'b0;
    r_kind                = KIND_SAMPLE;
    r_err                 = ERR_NONE;
    r_smp                 = 16'd0;

    case (phase)
      PH_RIFF_ID, PH_WAVE_ID: begin
        tag_next = tag_sh;
        pos_next = pos_inc;
        if (pos == 4'd3) begin
          if (tag_sh != ((phase == PH_RIFF_ID) ? TAG_RIFF : TAG_WAVE)) begin
            emit       = 1'b1;
            r_kind     = KIND_ERROR;
            r_err      = (phase == PH_RIFF_ID) ? ERR_BAD_RIFF : ERR_BAD_WAVE;
            phase_next = PH_HALT;
          end else if (phase == PH_RIFF_ID) begin
            phase_next = PH_RIFF_SIZE;
            pos_next   = 4'd0;
            tag_next   = 32'd0;
          end else begin
            phase_next = PH_SUB_ID;
            pos_next   = 4'd0;
            tag_next   = 32'd0;
            len_next   = 32'd0;
          end
        end
      end
      PH_RIFF_SIZE: begin
        // RIFF size carries nothing we need: count it off
        pos_next = pos_inc;
        if (pos == 4'd3) begin
          phase_next = PH_WAVE_ID;
          pos_next   = 4'd0;
          tag_next   = 32'd0;
        end
      end
      PH_SUB_ID: begin
        tag_next = tag_sh;
        pos_next = pos_inc;
        if (pos == 4'd3) begin
          phase_next = PH_SUB_SIZE;
          pos_next   = 4'd0;
          len_next   = 32'd0;
        end
      end
      PH_SUB_SIZE: begin
        len_next = len_put;
        pos_next = pos_inc;
        if (pos == 4'd3) begin
          pos_next = 4'd0;
          if (tag == TAG_FMT) begin
            phase_next = PH_FMT_BODY;
          end else if (tag == TAG_DATA &&
                       held_bits != BITS_8 && held_bits != BITS_16) begin
            emit       = 1'b1;
            r_kind     = KIND_ERROR;
            r_err      = ERR_UNSUP_BITS;
            phase_next = PH_HALT;
          end else if (len_put == 32'd0) begin
            phase_next = PH_SUB_ID;
            tag_next   = 32'd0;
          end else begin
            phase_next = (tag == TAG_DATA) ? PH_DATA : PH_SKIP;
          end
        end
      end
      PH_FMT_BODY: begin
        // Capture the 16 body bytes into the held fmt fields
        if (pos < 4'd2) begin
          held_format_tag_next[{pos[0], 3'b000} +: 8] = data_byte;
        end else if (pos < 4'd4) begin
          held_channels_next[{pos[0], 3'b000} +: 8] = data_byte;
        end else if (pos < 4'd8) begin
          held_rate_next[{pos[1:0], 3'b000} +: 8] = data_byte;
        end else if (pos < 4'd12) begin
          held_byte_rate_next[{pos[1:0], 3'b000} +: 8] = data_byte;
        end else if (pos < 4'd14) begin
          held_block_align_next[{pos[0], 3'b000} +: 8] = data_byte;
        end else begin
          held_bits_next[{pos[0], 3'b000} +: 8] = data_byte;
        end
        pos_next = pos_inc;
        if (pos == 4'd15) begin
          emit     = 1'b1;
          r_kind   = KIND_FORMAT;
          pos_next = 4'd0;
          if (len > FMT_BODY_BYTES) begin
            len_next   = len - FMT_BODY_BYTES;
            phase_next = PH_SKIP;
          end else begin
            phase_next = PH_SUB_ID;
            tag_next   = 32'd0;
            len_next   = 32'd0;
          end
        end
      end
      PH_SKIP: begin
        len_next = len - 32'd1;
        if (len == 32'd1) begin
          phase_next = PH_SUB_ID;
          pos_next   = 4'd0;
          tag_next   = 32'd0;
        end
      end
      PH_DATA: begin
        if (held_bits == BITS_8) begin
          emit  = 1'b1;
          r_smp = {~data_byte[7], data_byte[6:0], 8'h00};
        end else if (!pos[0]) begin
          low_byte_next = data_byte;
        end else begin
          emit  = 1'b1;
          r_smp = {data_byte, low_byte};
        end
        pos_next = {3'b000, ~pos[0]};
        len_next = len - 32'd1;
        if (len == 32'd1) begin
          phase_next = PH_SUB_ID;
          pos_next   = 4'd0;
          tag_next   = 32'd0;
        end
      end
      default: begin
      end
    endcase

    // Final byte: report where parsing stands unless this byte already gave a result or parsing has halted
    if (stream_end && !emit && phase_next != PH_HALT) begin
      emit   = 1'b1;
      r_kind = KIND_ERROR;
      case (phase_next)
        PH_RIFF_ID:   r_err = ERR_BAD_RIFF;
        PH_RIFF_SIZE: r_err = ERR_TRUNC_HEADER;
        PH_WAVE_ID:   r_err = ERR_BAD_WAVE;
        PH_SUB_ID: begin
          if (pos_next != 4'd0) begin
            r_err = ERR_TRUNC_CHUNK;
          end else begin
            r_kind = KIND_EOF;
          end
        end
        PH_SUB_SIZE, PH_FMT_BODY: r_err = ERR_TRUNC_HEADER;
        default: r_kind = KIND_EOF;
      endcase
    end

    res_next.kind             = r_kind;
    res_next.error_code       = r_err;
    res_next.sample_value     = r_smp;
    res_next.channel_count    = held_channels_next;
    res_next.rate_hz          = held_rate_next;
    res_next.sample_bits      = held_bits_next;
    res_next.format_tag       = held_format_tag_next;
    res_next.bytes_per_second = held_byte_rate_next;
    res_next.frame_bytes      = held_block_align_next;
    res_next.is_final         = stream_end;
  end

  // Parse state: the final byte returns everything to its reset value
  always_ff @(posedge clk) begin
    if (rst || (accept && stream_end)) begin
      phase            <= PH_RIFF_ID;
      pos              <= 4'd0;
      tag              <= 32'd0;
      len              <= 32'd0;
      held_format_tag  <= 16'd0;
      held_channels    <= 16'd0;
      held_rate        <= 32'd0;
      held_byte_rate   <= 32'd0;
      held_block_align <= 16'd0;
      held_bits        <= 16'd0;
      low_byte         <= 8'd0;
    end else if (accept) begin
      phase            <= phase_next;
      pos              <= pos_next;
      tag              <= tag_next;
      len              <= len_next;
      held_format_tag  <= held_format_tag_next;
      held_channels    <= held_channels_next;
      held_rate        <= held_rate_next;
      held_byte_rate   <= held_byte_rate_next;
      held_block_align <= held_block_align_next;
      held_bits        <= held_bits_next;
      low_byte         <= low_byte_next;
    end
  end

  // Output valid flags: a new request lands in the result register if it is free
  // or being taken, otherwise in the skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (accept && emit) begin
      if (!out_valid || out_ready) begin
        out_valid <= 1'b1;
      end else begin
        skid_full <= 1'b1;
      end
    end else if (out_valid && out_ready) begin
      if (skid_full) begin
        skid_full <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload: no reset needed
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      if (!out_valid || out_ready) begin
        res <= res_next;
      end else begin
        skid <= res_next;
      end
    end else if (out_valid && out_ready && skid_full) begin
      res <= skid;
    end
  end

  assign kind             = res.kind;
  assign error_code       = res.error_code;
  assign sample_value     = res.sample_value;
  assign channel_count    = res.channel_count;
  assign rate_hz          = res.rate_hz;
  assign sample_bits      = res.sample_bits;
  assign format_tag       = res.format_tag;
  assign bytes_per_second = res.bytes_per_second;
  assign frame_bytes      = res.frame_bytes;
  assign is_final         = res.is_final;

endmodule

// File: src/wps_checker.sv
`timescale 1ns / 1ps

module wps_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         kind,
  input logic [2:0]         error_code,
  input logic signed [15:0] sample_value,
  input logic               is_final
);
  import wps_pkg::*;

  // Hold a stalled result request
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(error_code)
      && $stable(sample_value) && $stable(is_final))
    else $error("stalled result changed");

  // Input stalls only while both output entries are occupied
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no pending result");

  // End of file is reported only on the final byte
  a_eof_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_EOF |-> is_final && error_code == ERR_NONE)
    else $error("end of file without final flag");

  // Non-sample results carry a zero sample; error codes stay in range
  a_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind == KIND_SAMPLE || sample_value == 16'sd0)
      && (kind == KIND_ERROR || error_code == ERR_NONE)
      && error_code <= ERR_UNSUP_BITS)
    else $error("result fields inconsistent with kind");

endmodule

bind wav_pcm_stream_parser wps_checker u_wps_checker (.*);
